FILE: rtl/bship_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bship_pkg
// Shared types, constants and fixed-point helpers of the Burning Ship unit.
// ----------------------------------------------------------------------------
package bship_pkg;

    localparam int C_IMAGE_WIDTH  = 1024;
    localparam int C_IMAGE_HEIGHT = 1024;
    localparam int C_QUEUE_DEPTH  = 2;

    localparam int C_FRAC_BITS = 28;
    localparam int C_WORD_W    = C_FRAC_BITS + 4;
    localparam int C_MAG_W     = C_WORD_W - 1;
    localparam int C_PROD_W    = 2 * C_MAG_W;
    localparam int C_WIDE_W    = 2 * C_WORD_W;

    localparam int C_PIX_W     = 10;
    localparam int C_CENTER_W  = 32;
    localparam int C_STEP_W    = 31;
    localparam int C_COUNT_W   = 16;

    localparam int C_S_TDATA_W = ((2 * C_PIX_W + 7) / 8) * 8;
    localparam int C_M_TDATA_W = ((C_COUNT_W + 7) / 8) * 8;
    localparam int C_APB_W     = 32;

    localparam int C_NUM_REGS  = 5;
    localparam int C_PADDR_W   = $clog2(4 * C_NUM_REGS);
    localparam int C_IDX_W     = C_PADDR_W - 2;

    localparam logic [C_IDX_W-1:0] C_REG_CENTER_RE = C_IDX_W'(0);
    localparam logic [C_IDX_W-1:0] C_REG_CENTER_IM = C_IDX_W'(1);
    localparam logic [C_IDX_W-1:0] C_REG_STEP_RE   = C_IDX_W'(2);
    localparam logic [C_IDX_W-1:0] C_REG_STEP_IM   = C_IDX_W'(3);
    localparam logic [C_IDX_W-1:0] C_REG_ITER_LIMIT = C_IDX_W'(4);

    localparam logic [C_STEP_W-1:0]  C_STEP_RE_RST  = C_STEP_W'(2952790);
    localparam logic [C_STEP_W-1:0]  C_STEP_IM_RST  = C_STEP_W'(2684354);
    localparam logic [C_COUNT_W-1:0] C_ITER_LIMIT_RST = C_COUNT_W'(50);

    localparam logic [C_WORD_W-1:0] C_FOUR_FIX = C_WORD_W'(4) << C_FRAC_BITS;

    localparam logic signed [C_WIDE_W-1:0] C_WMAX_WIDE =
        {{(C_WIDE_W - C_WORD_W + 1){1'b0}}, {(C_WORD_W - 1){1'b1}}};
    localparam logic signed [C_WIDE_W-1:0] C_WMIN_WIDE =
        {{(C_WIDE_W - C_WORD_W + 1){1'b1}}, {(C_WORD_W - 1){1'b0}}};

    typedef logic signed [C_WORD_W-1:0] t_word;
    typedef logic        [C_MAG_W-1:0]  t_mag;
    typedef logic signed [C_WIDE_W-1:0] t_wide;

    typedef struct packed {
        t_word cr;
        t_word ci;
    } t_point;

    typedef struct packed {
        logic signed [C_CENTER_W-1:0] center_re;
        logic signed [C_CENTER_W-1:0] center_im;
        logic        [C_STEP_W-1:0]   step_re;
        logic        [C_STEP_W-1:0]   step_im;
    } t_view;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EVAL,
        S_DONE
    } t_back_state;

    function automatic t_word clamp_word(input t_wide v);
        t_word r;
        if (v > C_WMAX_WIDE) begin
            r = C_WMAX_WIDE[C_WORD_W-1:0];
        end else if (v < C_WMIN_WIDE) begin
            r = C_WMIN_WIDE[C_WORD_W-1:0];
        end else begin
            r = v[C_WORD_W-1:0];
        end
        return r;
    endfunction

    // most negative word saturates to the largest magnitude
    function automatic t_mag magnitude(input t_word v);
        t_word n;
        t_mag  r;
        n = -v;
        if (!v[C_WORD_W-1]) begin
            r = v[C_MAG_W-1:0];
        end else if (v == C_WMIN_WIDE[C_WORD_W-1:0]) begin
            r = '1;
        end else begin
            r = n[C_MAG_W-1:0];
        end
        return r;
    endfunction

    function automatic t_mag sat_shift(input logic [C_PROD_W-1:0] p, input int s);
        logic [C_PROD_W-1:0] q;
        t_mag                r;
        q = p >> s;
        if (|q[C_PROD_W-1:C_MAG_W]) begin
            r = '1;
        end else begin
            r = q[C_MAG_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/bship_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bship_front
// Maps an incoming pixel to its point c of the plane and hands it to the queue.
// ----------------------------------------------------------------------------
module bship_front #(
    parameter int IMAGE_WIDTH  = bship_pkg::C_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = bship_pkg::C_IMAGE_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bship_pkg::C_PIX_W-1:0]   i_pixel_x,
    input  logic [bship_pkg::C_PIX_W-1:0]   i_pixel_y,
    input  bship_pkg::t_view                i_view,
    output logic                            o_push_valid,
    input  logic                            i_push_ready,
    output bship_pkg::t_point               o_point
);

    localparam int HALF_W   = IMAGE_WIDTH / 2;
    localparam int HALF_H   = IMAGE_HEIGHT / 2;
    localparam int OFF_X_W  = ((bship_pkg::C_PIX_W > $clog2(HALF_W)) ?
                               bship_pkg::C_PIX_W : $clog2(HALF_W)) + 1;
    localparam int OFF_Y_W  = ((bship_pkg::C_PIX_W > $clog2(HALF_H)) ?
                               bship_pkg::C_PIX_W : $clog2(HALF_H)) + 1;
    localparam int PROD_X_W = OFF_X_W + bship_pkg::C_STEP_W + 1;
    localparam int PROD_Y_W = OFF_Y_W + bship_pkg::C_STEP_W + 1;
    localparam int WIDE_W   = bship_pkg::C_WIDE_W;

    logic signed [OFF_X_W-1:0]  w_off_x;
    logic signed [OFF_Y_W-1:0]  w_off_y;
    logic signed [PROD_X_W-1:0] w_prod_x;
    logic signed [PROD_Y_W-1:0] w_prod_y;
    logic signed [PROD_X_W-1:0] r_prod_x;
    logic signed [PROD_Y_W-1:0] r_prod_y;
    logic                       r_valid;
    logic                       w_accept;

    assign w_off_x  = signed'(OFF_X_W'(i_pixel_x)) - signed'(OFF_X_W'(HALF_W));
    assign w_off_y  = signed'(OFF_Y_W'(i_pixel_y)) - signed'(OFF_Y_W'(HALF_H));
    assign w_prod_x = w_off_x * signed'({1'b0, i_view.step_re});
    assign w_prod_y = w_off_y * signed'({1'b0, i_view.step_im});

    assign o_ready  = !r_valid || i_push_ready;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prod_x <= w_prod_x;
            r_prod_y <= w_prod_y;
        end
    end

    assign o_push_valid = r_valid;
    assign o_point.cr   = bship_pkg::clamp_word(WIDE_W'(i_view.center_re) + WIDE_W'(r_prod_x));
    assign o_point.ci   = bship_pkg::clamp_word(WIDE_W'(i_view.center_im) + WIDE_W'(r_prod_y));

endmodule

FILE: rtl/bship_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bship_fifo
// Short queue of mapped points between the front and the iteration engine.
// ----------------------------------------------------------------------------
module bship_fifo #(
    parameter int DEPTH = bship_pkg::C_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bship_pkg::t_point i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output bship_pkg::t_point o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bship_pkg::t_point r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/bship_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bship_back
// Iteration engine: squares the folded orbit, tests escape and limit, and
// holds the finished count in an output register.
// ----------------------------------------------------------------------------
module bship_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  bship_pkg::t_point               i_point,
    input  logic [bship_pkg::C_COUNT_W-1:0] i_iter_limit,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bship_pkg::C_COUNT_W-1:0] o_count,
    output logic                            o_escaped
);

    localparam int WORD_W = bship_pkg::C_WORD_W;
    localparam int WIDE_W = bship_pkg::C_WIDE_W;
    localparam int PROD_W = bship_pkg::C_PROD_W;

    bship_pkg::t_back_state r_state;
    bship_pkg::t_back_state n_state;

    bship_pkg::t_word               r_cr;
    bship_pkg::t_word               r_ci;
    bship_pkg::t_word               r_zr;
    bship_pkg::t_word               r_zi;
    logic [bship_pkg::C_COUNT_W-1:0] r_count;
    logic [PROD_W-1:0]              r_p_aa;
    logic [PROD_W-1:0]              r_p_bb;
    logic [PROD_W-1:0]              r_p_ab;
    logic                           r_esc;
    logic                           r_out_valid;
    logic [bship_pkg::C_COUNT_W-1:0] r_out_count;
    logic                           r_out_esc;

    bship_pkg::t_mag   w_a;
    bship_pkg::t_mag   w_b;
    bship_pkg::t_mag   w_sr;
    bship_pkg::t_mag   w_si;
    bship_pkg::t_mag   w_sab;
    logic [WORD_W-1:0] w_sum;
    logic              w_limit;
    logic              w_escape;
    bship_pkg::t_word  w_zr_next;
    bship_pkg::t_word  w_zi_next;
    logic              w_out_free;
    logic              w_load;
    logic              w_mul;
    logic              w_iter;
    logic              w_fin;
    logic              w_emit;

    assign w_a       = bship_pkg::magnitude(r_zr);
    assign w_b       = bship_pkg::magnitude(r_zi);
    assign w_sr      = bship_pkg::sat_shift(r_p_aa, bship_pkg::C_FRAC_BITS);
    assign w_si      = bship_pkg::sat_shift(r_p_bb, bship_pkg::C_FRAC_BITS);
    assign w_sab     = bship_pkg::sat_shift(r_p_ab, bship_pkg::C_FRAC_BITS - 1);
    assign w_sum     = {1'b0, w_sr} + {1'b0, w_si};
    assign w_limit   = (r_count >= i_iter_limit);
    assign w_escape  = (w_sum >= bship_pkg::C_FOUR_FIX);
    assign w_zr_next = bship_pkg::clamp_word(WIDE_W'(signed'({1'b0, w_sr}))
                                           - WIDE_W'(signed'({1'b0, w_si}))
                                           + WIDE_W'(r_cr));
    assign w_zi_next = bship_pkg::clamp_word(WIDE_W'(signed'({1'b0, w_sab}))
                                           + WIDE_W'(r_ci));
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bship_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = bship_pkg::S_MUL;
                end
            end
            bship_pkg::S_MUL: begin
                n_state = bship_pkg::S_EVAL;
            end
            bship_pkg::S_EVAL: begin
                if (w_limit || w_escape) begin
                    n_state = bship_pkg::S_DONE;
                end else begin
                    n_state = bship_pkg::S_MUL;
                end
            end
            bship_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = bship_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bship_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_ready = 1'b0;
        w_mul     = 1'b0;
        w_iter    = 1'b0;
        w_fin     = 1'b0;
        w_emit    = 1'b0;
        case (r_state)
            bship_pkg::S_IDLE: begin
                o_q_ready = 1'b1;
            end
            bship_pkg::S_MUL: begin
                w_mul = 1'b1;
            end
            bship_pkg::S_EVAL: begin
                w_iter = !w_limit && !w_escape;
                w_fin  = w_limit || w_escape;
            end
            bship_pkg::S_DONE: begin
                w_emit = w_out_free;
            end
            default: begin
                o_q_ready = 1'b0;
            end
        endcase
    end

    assign w_load = o_q_ready && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bship_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cr    <= i_point.cr;
            r_ci    <= i_point.ci;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if (w_mul) begin
            r_p_aa <= w_a * w_a;
            r_p_bb <= w_b * w_b;
            r_p_ab <= w_a * w_b;
        end
        if (w_iter) begin
            r_zr    <= w_zr_next;
            r_zi    <= w_zi_next;
            r_count <= r_count + 1'b1;
        end
        // limit wins over a simultaneous escape
        if (w_fin) begin
            r_esc <= !w_limit;
        end
        if (w_emit) begin
            r_out_count <= r_count;
            r_out_esc   <= r_esc;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_count   = r_out_count;
    assign o_escaped = r_out_esc;

endmodule

FILE: rtl/burning_ship_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burning_ship_escape_time
// Burning Ship escape-time unit: pixel in, iteration count and escape flag out.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid / tready         pixel_x, pixel_y
//   m_axis    out        tvalid / tready         iteration_count, escaped
//   apb       in         psel, penable, pready   five view registers
//
// In the iteration engine an item runs N iterations, N being at most the
// iteration limit: each iteration is a multiply state on three multipliers
// and an evaluate state. The front registers the scaled offsets of a pixel
// and a two-entry queue lets it run ahead. Reset is synchronous and
// active low; it empties the pipeline and restores the register defaults. A
// stalled result waits in the output register while the next point is already
// iterated.
// ----------------------------------------------------------------------------
module burning_ship_escape_time #(
    parameter int IMAGE_WIDTH  = bship_pkg::C_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = bship_pkg::C_IMAGE_HEIGHT,
    parameter int QUEUE_DEPTH  = bship_pkg::C_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_x [9:0], pixel_y [19:10], zero pad
    input  logic [bship_pkg::C_S_TDATA_W-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // iteration_count [15:0]
    output logic [bship_pkg::C_M_TDATA_W-1:0] m_axis_tdata,
    // escaped [0]
    output logic                              m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bship_pkg::C_PADDR_W-1:0]   paddr,
    input  logic [bship_pkg::C_APB_W-1:0]     pwdata,
    output logic [bship_pkg::C_APB_W-1:0]     prdata,
    output logic                              pready
);

    localparam int PIX_W   = bship_pkg::C_PIX_W;
    localparam int COUNT_W = bship_pkg::C_COUNT_W;
    localparam int APB_W   = bship_pkg::C_APB_W;

    logic signed [bship_pkg::C_CENTER_W-1:0] r_center_re;
    logic signed [bship_pkg::C_CENTER_W-1:0] r_center_im;
    logic [bship_pkg::C_STEP_W-1:0]          r_step_re;
    logic [bship_pkg::C_STEP_W-1:0]          r_step_im;
    logic [COUNT_W-1:0]                      r_iter_limit;

    logic                          w_wr;
    logic [bship_pkg::C_IDX_W-1:0] w_idx;
    bship_pkg::t_view              w_view;
    logic                          w_push_valid;
    logic                          w_push_ready;
    bship_pkg::t_point             w_push_point;
    logic                          w_q_valid;
    logic                          w_q_ready;
    bship_pkg::t_point             w_q_point;
    logic [COUNT_W-1:0]            w_count;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[bship_pkg::C_PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re  <= '0;
            r_center_im  <= '0;
            r_step_re    <= bship_pkg::C_STEP_RE_RST;
            r_step_im    <= bship_pkg::C_STEP_IM_RST;
            r_iter_limit <= bship_pkg::C_ITER_LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                bship_pkg::C_REG_CENTER_RE:  r_center_re  <= signed'(pwdata);
                bship_pkg::C_REG_CENTER_IM:  r_center_im  <= signed'(pwdata);
                bship_pkg::C_REG_STEP_RE:    r_step_re    <= pwdata[bship_pkg::C_STEP_W-1:0];
                bship_pkg::C_REG_STEP_IM:    r_step_im    <= pwdata[bship_pkg::C_STEP_W-1:0];
                bship_pkg::C_REG_ITER_LIMIT: r_iter_limit <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bship_pkg::C_REG_CENTER_RE:  prdata = APB_W'(r_center_re);
            bship_pkg::C_REG_CENTER_IM:  prdata = APB_W'(r_center_im);
            bship_pkg::C_REG_STEP_RE:    prdata = APB_W'(r_step_re);
            bship_pkg::C_REG_STEP_IM:    prdata = APB_W'(r_step_im);
            bship_pkg::C_REG_ITER_LIMIT: prdata = APB_W'(r_iter_limit);
            default:                     prdata = '0;
        endcase
    end

    assign w_view.center_re = r_center_re;
    assign w_view.center_im = r_center_im;
    assign w_view.step_re   = r_step_re;
    assign w_view.step_im   = r_step_im;

    bship_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixel_x    (s_axis_tdata[PIX_W-1:0]),
        .i_pixel_y    (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_view       (w_view),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_point      (w_push_point)
    );

    bship_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_push_valid),
        .o_ready (w_push_ready),
        .i_data  (w_push_point),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_point)
    );

    bship_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_ready    (w_q_ready),
        .i_point      (w_q_point),
        .i_iter_limit (r_iter_limit),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_count      (w_count),
        .o_escaped    (m_axis_tuser)
    );

    assign m_axis_tdata = bship_pkg::C_M_TDATA_W'(w_count);

endmodule

FILE: rtl/bship_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bship_checker
// Port-level checks of the Burning Ship unit, bound to the top level.
// ----------------------------------------------------------------------------
module bship_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [bship_pkg::C_M_TDATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [bship_pkg::C_PADDR_W-1:0]   paddr,
    input logic [bship_pkg::C_APB_W-1:0]     pwdata,
    input logic [bship_pkg::C_APB_W-1:0]     prdata,
    input logic                              pready
);

    localparam int PADDR_W = bship_pkg::C_PADDR_W;
    localparam int COUNT_W = bship_pkg::C_COUNT_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // the first iteration starts at the origin and never escapes
    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[COUNT_W-1:0] != '0)
        else $error("escape reported with no iteration");

    a_limit_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready &&
        paddr[PADDR_W-1:2] == bship_pkg::C_REG_ITER_LIMIT |=>
            paddr[PADDR_W-1:2] != bship_pkg::C_REG_ITER_LIMIT ||
            prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))
        else $error("iteration limit read back wrong");

endmodule

bind burning_ship_escape_time bship_checker u_bship_checker (.*);
